>>> sv/assert_macros.svh
// Assertion macros included by the merge stage RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_KNOWN(label, clk, rst_n, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error("%m unknown");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_KNOWN(label, clk, rst_n, sig)
`endif
`endif

>>> sv/artu_pkg.sv
// Package: types, command codes and GF(2^8) helpers for the round transform unit
`default_nettype none
package artu_pkg;
    typedef enum logic [2:0] {
        CMD_SUB       = 3'd0,
        CMD_SHIFT     = 3'd1,
        CMD_MIX       = 3'd2,
        CMD_INV_SUB   = 3'd3,
        CMD_INV_SHIFT = 3'd4,
        CMD_INV_MIX   = 3'd5
    } t_cmd;

    localparam int unsigned NumLanes = 4;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] state_hi;
        logic [63:0] state_lo;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_beat;

    // multiply by x modulo 0x11B
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        gf_mul = acc;
    endfunction

    // forward S-box table
    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[v];
    endfunction

    // inverse S-box table
    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[v];
    endfunction
endpackage
`default_nettype wire

>>> sv/artu_lane.sv
// One column lane: S-box and MixColumns on four bytes
`default_nettype none
module artu_lane
    import artu_pkg::*;
(
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_col,
    output logic      [31:0] o_col
);
    logic [7:0] b [4];
    logic [7:0] y [4];
    logic [7:0] c [4];

    // split column into bytes
    always_comb begin
        for (int r = 0; r < 4; r++) b[r] = i_col[8*r +: 8];
    end

    // transform per command
    always_comb begin
        for (int r = 0; r < 4; r++) y[r] = b[r];
        c = '{8'h02, 8'h03, 8'h01, 8'h01};
        case (i_cmd)
            CMD_SUB: begin
                for (int r = 0; r < 4; r++) y[r] = sbox(b[r]);
            end
            CMD_INV_SUB: begin
                for (int r = 0; r < 4; r++) y[r] = inv_sbox(b[r]);
            end
            CMD_MIX: begin
                c = '{8'h02, 8'h03, 8'h01, 8'h01};
                for (int r = 0; r < 4; r++)
                    y[r] = gf_mul(b[r], c[0]) ^ gf_mul(b[(r+1)%4], c[1])
                         ^ gf_mul(b[(r+2)%4], c[2]) ^ gf_mul(b[(r+3)%4], c[3]);
            end
            CMD_INV_MIX: begin
                c = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
                for (int r = 0; r < 4; r++)
                    y[r] = gf_mul(b[r], c[0]) ^ gf_mul(b[(r+1)%4], c[1])
                         ^ gf_mul(b[(r+2)%4], c[2]) ^ gf_mul(b[(r+3)%4], c[3]);
            end
            default: begin
            end
        endcase
    end

    // pack column
    always_comb begin
        for (int r = 0; r < 4; r++) o_col[8*r +: 8] = y[r];
    end
endmodule
`default_nettype wire

>>> sv/artu_merge.sv
// Merge stage: row shifts on the input state, result select and output register with skid
`default_nettype none
`include "assert_macros.svh"
module artu_merge
    import artu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_cmd       i_cmd,
    input  wire logic [127:0] i_lanes,
    input  wire logic [127:0] i_state,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_beat       o_data
);
    logic [127:0] n_shift;
    logic [127:0] n_res;
    logic         r_valid;
    t_out_beat    r_data;
    logic         r_skid_valid;
    t_out_beat    r_skid;

    // row rotation across columns
    always_comb begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (i_cmd == CMD_INV_SHIFT)
                    n_shift[8*(r+4*c) +: 8] = i_state[8*(r+4*((c+4-r)%4)) +: 8];
                else
                    n_shift[8*(r+4*c) +: 8] = i_state[8*(r+4*((c+r)%4)) +: 8];
            end
    end

    // pick result source
    always_comb begin
        case (i_cmd)
            CMD_SHIFT, CMD_INV_SHIFT: n_res = n_shift;
            default:                  n_res = i_lanes;
        endcase
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // output register and skid beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_data       <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid;
                    if (i_valid) r_data <= t_out_beat'(n_res);
                end
            end else if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
                r_skid       <= t_out_beat'(n_res);
            end
        end
    end

    `ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_valid)
    `ASSERT_IMPL(a_hold_stalled, i_clk, i_rst_n, (r_valid && i_stall) |=> (r_valid && $stable(r_data)))
    `ASSERT_IMPL(a_skid_drains, i_clk, i_rst_n, (r_skid_valid && !i_stall) |=> !r_skid_valid)
endmodule
`default_nettype wire

>>> sv/aes_round_transform_unit_top.sv
// Top level: AES round transforms on a 128-bit state
//  channel | dir | handshake          | beat
//  in      | in  | i_valid / o_stall  | t_in_beat  (command, state_hi, state_lo)
//  out     | out | o_valid / i_stall  | t_out_beat (result_hi, result_lo)
// One beat per cycle unless a stall holds it; the result is registered in the output register.
// Four column lanes run S-box and MixColumns; the merge stage does row shifts.
// Reset clears the output and skid valid flags only.
// A held output stalls input once the one-entry skid beat fills.
`default_nettype none
module aes_round_transform_unit_top
    import artu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in_beat i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_beat o_data
);
    logic [127:0] w_state;
    logic [127:0] w_lanes;
    t_cmd         w_cmd;

    assign w_state = {i_data.state_hi, i_data.state_lo};
    assign w_cmd   = t_cmd'(i_data.command);

    // one lane per column
    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        artu_lane u_lane (
            .i_cmd (w_cmd),
            .i_col (w_state[32*g +: 32]),
            .o_col (w_lanes[32*g +: 32])
        );
    end

    artu_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (w_cmd),
        .i_lanes (w_lanes),
        .i_state (w_state),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the AES round transform unit: queued driver, clocked monitor, own predictor
`default_nettype none
module tb_top;
    import artu_pkg::*;

    localparam int RandomBeats = 1950;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    t_in_beat  pending_beats[$];
    t_out_beat expected_states[$];
    int        error_count;
    bit        stimulus_done;
    int        hold_off_left;

    aes_round_transform_unit_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Clock: period 10
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // GF(2^8) product over 0x11B
    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    // Inverse as a^254, zero maps to zero
    function automatic logic [7:0] field_inv(logic [7:0] a);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = a;
        for (int e = 254; e != 0; e >>= 1) begin
            if (e & 1) r = field_mul(r, p);
            p = field_mul(p, p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rot_byte(logic [7:0] v, int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sub_byte(logic [7:0] v);
        logic [7:0] b;
        b = field_inv(v);
        return b ^ rot_byte(b, 1) ^ rot_byte(b, 2) ^ rot_byte(b, 3) ^ rot_byte(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sub_byte(logic [7:0] v);
        return field_inv(rot_byte(v, 1) ^ rot_byte(v, 3) ^ rot_byte(v, 6) ^ 8'h05);
    endfunction

    // Transformed state for one input beat
    function automatic t_out_beat transform_state(t_in_beat beat);
        logic [7:0]   s[16];
        logic [7:0]   t[16];
        logic [7:0]   coef[4];
        logic [127:0] whole;
        logic [7:0]   acc;
        whole = {beat.state_hi, beat.state_lo};
        for (int n = 0; n < 16; n++) s[n] = whole[8*n +: 8];
        t = s;
        if (beat.command == CMD_INV_MIX) begin
            coef[0] = 8'h0E;
            coef[1] = 8'h0B;
            coef[2] = 8'h0D;
            coef[3] = 8'h09;
        end else begin
            coef[0] = 8'h02;
            coef[1] = 8'h03;
            coef[2] = 8'h01;
            coef[3] = 8'h01;
        end
        case (beat.command)
            CMD_SUB:     for (int n = 0; n < 16; n++) t[n] = sub_byte(s[n]);
            CMD_INV_SUB: for (int n = 0; n < 16; n++) t[n] = inv_sub_byte(s[n]);
            CMD_SHIFT:
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) t[r + 4*c] = s[r + 4*((c + r) & 3)];
            CMD_INV_SHIFT:
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) t[r + 4*c] = s[r + 4*((c + 4 - r) & 3)];
            CMD_MIX, CMD_INV_MIX:
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        acc = 8'h00;
                        for (int k = 0; k < 4; k++)
                            acc ^= field_mul(s[4*c + k], coef[(k + 4 - r) & 3]);
                        t[4*c + r] = acc;
                    end
            default: ;
        endcase
        for (int n = 0; n < 16; n++) whole[8*n +: 8] = t[n];
        return '{result_hi: whole[127:64], result_lo: whole[63:0]};
    endfunction

    function automatic int gap_length();
        if ($urandom_range(99) < 60) return 0;
        if ($urandom_range(99) < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Driver: advance on acceptance, insert random gaps
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) void'(pending_beats.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if ((i_valid ? pending_beats.size() > 0 : pending_beats.size() > 0)) begin
                i_valid <= 1'b1;
                i_data <= pending_beats[0];
                send_gap = gap_length();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random gaps plus long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (gap_length() > 0) && ($urandom_range(1) == 1);
        end
    end

    // Predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            expected_states.push_back(transform_state(i_data));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, o_data.result_hi,
                         o_data.result_lo);
                error_count++;
            end else begin
                if (o_data.result_hi !== expected_states[0].result_hi) begin
                    $display("%0t: result_hi expected %h actual %h", $time,
                             expected_states[0].result_hi, o_data.result_hi);
                    error_count++;
                end
                if (o_data.result_lo !== expected_states[0].result_lo) begin
                    $display("%0t: result_lo expected %h actual %h", $time,
                             expected_states[0].result_lo, o_data.result_lo);
                    error_count++;
                end
                void'(expected_states.pop_front());
            end
        end
    end

    function automatic t_in_beat make_beat(logic [2:0] cmd, logic [63:0] hi, logic [63:0] lo);
        return '{command: cmd, state_hi: hi, state_lo: lo};
    endfunction

    // Stimulus and end of run
    initial begin
        t_in_beat beat;
        error_count = 0;
        hold_off_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        // Directed: extremes and a byte ramp for every command, unused codes pass through
        for (int c = 0; c < 8; c++) begin
            pending_beats.push_back(make_beat(c[2:0], '0, '0));
            pending_beats.push_back(make_beat(c[2:0], '1, '1));
            pending_beats.push_back(make_beat(c[2:0], 64'h0f0e0d0c0b0a0908,
                                              64'h0706050403020100));
        end
        for (int n = 0; n < RandomBeats; n++) begin
            beat.command = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                   : 3'($urandom_range(5));
            beat.state_hi = rand_word();
            beat.state_lo = rand_word();
            pending_beats.push_back(beat);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // Long hold-off while the sender keeps offering
        wait (pending_beats.size() < RandomBeats);
        @(negedge i_clk);
        hold_off_left = 60;
        wait (pending_beats.size() == 0 && !i_valid);
        wait (expected_states.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_states.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
